// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers, clocked on aclk and quiet while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle that ante holds.
`define CSIT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante holds.
`define CSIT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/csit_pkg.sv =====
// ----------------------------------------------------------------------------
// csit_pkg
// Codes and types shared by the circle/segment intersection test unit.
// ----------------------------------------------------------------------------
package csit_pkg;

    // Command codes carried on s_tuser
    localparam logic CMD_INCLUSIVE = 1'b0;
    localparam logic CMD_STRICT    = 1'b1;

    // Register indexes, byte address = 4 * index
    localparam int unsigned REG_IDX_W = 2;
    localparam int unsigned ADDR_W    = 4;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [REG_IDX_W-1:0] REG_CENTER_X = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_Y = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_RADIUS   = 2'd2;

    // Number of register stages ahead of the output register
    localparam int unsigned STAGES = 7;

    // Per-item decision flags carried down the pipeline
    typedef struct packed {
        logic strict;    // strict perimeter-crossing mode
        logic reject;    // both ends past one side of the bounding square
        logic in1;       // start point strictly inside
        logic in2;       // end point strictly inside
        logic use_end;   // nearest point is an endpoint, not the foot
        logic end_near;  // that endpoint lies within the radius
    } flags_t;

endpackage

// ===== hw/rtl/circle_segment_intersect_test_unit.sv =====
// ----------------------------------------------------------------------------
// circle_segment_intersect_test_unit
// Tests one line segment per transfer against a configured circle.
// ----------------------------------------------------------------------------
// Each input transfer carries two endpoints and a mode bit; each produces one
// output transfer with the hit bit. The unit takes a new segment every clock
// unless a stalled output backs up the pipe of seven register stages plus the
// output register. That depth is set by the arithmetic chain of differences,
// products, sums and compares, and by the exact perpendicular-distance test,
// which squares values of 2*COORD_BITS+2 bits through split partial
// products, each multiplier at most (COORD_BITS+1) x (COORD_BITS+1) bits.
// Every stage has its own valid bit and advances when the stage below can take
// its contents, so bubbles close up while the output stalls and no result is
// dropped or repeated. The circle (center_x, center_y, radius) sits in APB
// registers at byte addresses 0x0, 0x4 and 0x8; write them only while no
// segment is in flight. All compares are exact; distances compare as squares.
// ----------------------------------------------------------------------------
module circle_segment_intersect_test_unit #(
    parameter int unsigned COORD_BITS = 24
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // {end_y, end_x, start_y, start_x}, start_x at bit 0, zero padded to bytes
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]    s_tdata,
    // command (bit 0)
    input  logic                                 s_tuser,
    // Result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // hit (bit 0), zero padded
    output logic [7:0]                           m_tdata,
    // Configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [csit_pkg::ADDR_W-1:0]          paddr,
    input  logic [csit_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [csit_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                 pready
);

`include "assert_macros.svh"

    localparam int unsigned C  = COORD_BITS;
    localparam int unsigned D  = C + 1;        // coordinate differences
    localparam int unsigned P  = 2 * C + 2;    // signed products
    localparam int unsigned S  = 2 * C + 3;    // sums of products
    localparam int unsigned M  = 2 * C + 2;    // magnitudes to be squared
    localparam int unsigned K  = C + 1;        // split point of a magnitude
    localparam int unsigned W  = 2 * M;        // full squares
    localparam int unsigned NS = csit_pkg::STAGES;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic signed [C-1:0] center_x_reg;
    logic signed [C-1:0] center_y_reg;
    logic        [C-2:0] radius_reg;

    logic                              cfg_write;
    logic [csit_pkg::REG_IDX_W-1:0]    cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[csit_pkg::ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_reg   <= '0;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                csit_pkg::REG_CENTER_X: center_x_reg <= $signed(pwdata[C-1:0]);
                csit_pkg::REG_CENTER_Y: center_y_reg <= $signed(pwdata[C-1:0]);
                csit_pkg::REG_RADIUS:   radius_reg   <= pwdata[C-2:0];
                default: ;  // drop writes past the register list
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            csit_pkg::REG_CENTER_X: prdata = csit_pkg::CFG_DATA_W'(center_x_reg);
            csit_pkg::REG_CENTER_Y: prdata = csit_pkg::CFG_DATA_W'(center_y_reg);
            csit_pkg::REG_RADIUS:   prdata = csit_pkg::CFG_DATA_W'(radius_reg);
            default:                prdata = '0;
        endcase
    end

    // Radius as a non-negative signed value
    logic signed [C-1:0] radius_s;
    assign radius_s = $signed({1'b0, radius_reg});

    // ------------------------------------------------------------------------
    // Flow control: a stage loads when it is empty or its contents move on
    // ------------------------------------------------------------------------
    logic [NS:1]   stage_valid_reg;
    logic [NS+1:1] stage_en;
    logic          m_tvalid_reg;
    logic [7:0]    m_tdata_reg;

    always_comb begin
        stage_en[NS+1] = !m_tvalid_reg || m_tready;
        for (int i = NS; i >= 1; i--) begin
            stage_en[i] = !stage_valid_reg[i] || stage_en[i+1];
        end
    end

    assign s_tready = stage_en[1];
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (stage_en[1]) begin
                stage_valid_reg[1] <= s_tvalid;
            end
            for (int i = 2; i <= NS; i++) begin
                if (stage_en[i]) begin
                    stage_valid_reg[i] <= stage_valid_reg[i-1];
                end
            end
            if (stage_en[NS+1]) begin
                m_tvalid_reg <= stage_valid_reg[NS];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: unpack, coordinate differences, bounding-square reject
    // ------------------------------------------------------------------------
    logic signed [C-1:0] in_x1, in_y1, in_x2, in_y2;
    logic signed [D-1:0] x1e, y1e, x2e, y2e, cxe, cye, rde;
    logic signed [D-1:0] hx, lx, hy, ly;
    csit_pkg::flags_t    s1_flags_next;

    assign in_x1 = $signed(s_tdata[C-1:0]);
    assign in_y1 = $signed(s_tdata[2*C-1:C]);
    assign in_x2 = $signed(s_tdata[3*C-1:2*C]);
    assign in_y2 = $signed(s_tdata[4*C-1:3*C]);

    assign x1e = D'(in_x1);
    assign y1e = D'(in_y1);
    assign x2e = D'(in_x2);
    assign y2e = D'(in_y2);
    assign cxe = D'(center_x_reg);
    assign cye = D'(center_y_reg);
    assign rde = D'(radius_s);
    assign hx  = cxe + rde;
    assign lx  = cxe - rde;
    assign hy  = cye + rde;
    assign ly  = cye - rde;

    always_comb begin
        s1_flags_next        = '0;
        s1_flags_next.strict = (s_tuser == csit_pkg::CMD_STRICT);
        s1_flags_next.reject = (x1e > hx && x2e > hx) || (x1e < lx && x2e < lx) ||
                               (y1e > hy && y2e > hy) || (y1e < ly && y2e < ly);
    end

    csit_pkg::flags_t    s1_flags_reg;
    logic signed [D-1:0] s1_dx_reg, s1_dy_reg, s1_wx_reg, s1_wy_reg, s1_vx_reg, s1_vy_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            s1_flags_reg <= s1_flags_next;
            s1_dx_reg    <= x2e - x1e;
            s1_dy_reg    <= y2e - y1e;
            s1_wx_reg    <= cxe - x1e;
            s1_wy_reg    <= cye - y1e;
            s1_vx_reg    <= cxe - x2e;
            s1_vy_reg    <= cye - y2e;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: all first-level products
    // ------------------------------------------------------------------------
    csit_pkg::flags_t    s2_flags_reg;
    logic signed [P-1:0] s2_wdx_reg, s2_wdy_reg;     // projection terms
    logic signed [P-1:0] s2_dx2_reg, s2_dy2_reg;     // segment length terms
    logic signed [P-1:0] s2_wx2_reg, s2_wy2_reg;     // start distance terms
    logic signed [P-1:0] s2_vx2_reg, s2_vy2_reg;     // end distance terms
    logic signed [P-1:0] s2_ca_reg, s2_cb_reg;       // cross product terms
    logic signed [P-1:0] s2_rdx_reg, s2_rdy_reg;     // radius times direction
    logic signed [S-1:0] s2_r2_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            s2_flags_reg <= s1_flags_reg;
            s2_wdx_reg   <= P'(s1_wx_reg) * P'(s1_dx_reg);
            s2_wdy_reg   <= P'(s1_wy_reg) * P'(s1_dy_reg);
            s2_dx2_reg   <= P'(s1_dx_reg) * P'(s1_dx_reg);
            s2_dy2_reg   <= P'(s1_dy_reg) * P'(s1_dy_reg);
            s2_wx2_reg   <= P'(s1_wx_reg) * P'(s1_wx_reg);
            s2_wy2_reg   <= P'(s1_wy_reg) * P'(s1_wy_reg);
            s2_vx2_reg   <= P'(s1_vx_reg) * P'(s1_vx_reg);
            s2_vy2_reg   <= P'(s1_vy_reg) * P'(s1_vy_reg);
            s2_ca_reg    <= P'(s1_dx_reg) * P'(s1_wy_reg);
            s2_cb_reg    <= P'(s1_dy_reg) * P'(s1_wx_reg);
            s2_rdx_reg   <= P'(radius_s) * P'(s1_dx_reg);
            s2_rdy_reg   <= P'(radius_s) * P'(s1_dy_reg);
            s2_r2_reg    <= S'(radius_s) * S'(radius_s);
        end
    end

    // ------------------------------------------------------------------------
    // Stage 3: sums of products
    // ------------------------------------------------------------------------
    csit_pkg::flags_t    s3_flags_reg;
    logic signed [S-1:0] s3_t_reg, s3_dd_reg, s3_d1_reg, s3_d2_reg, s3_cr_reg, s3_r2_reg;
    logic signed [P-1:0] s3_rdx_reg, s3_rdy_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            s3_flags_reg <= s2_flags_reg;
            s3_t_reg     <= S'(s2_wdx_reg) + S'(s2_wdy_reg);
            s3_dd_reg    <= S'(s2_dx2_reg) + S'(s2_dy2_reg);
            s3_d1_reg    <= S'(s2_wx2_reg) + S'(s2_wy2_reg);
            s3_d2_reg    <= S'(s2_vx2_reg) + S'(s2_vy2_reg);
            s3_cr_reg    <= S'(s2_ca_reg) - S'(s2_cb_reg);
            s3_r2_reg    <= s2_r2_reg;
            s3_rdx_reg   <= s2_rdx_reg;
            s3_rdy_reg   <= s2_rdy_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 4: endpoint and projection compares, magnitudes
    // ------------------------------------------------------------------------
    csit_pkg::flags_t s4_flags_next;
    logic             before_start, past_end;

    assign before_start = (s3_t_reg <= 0);
    assign past_end     = (s3_t_reg >= s3_dd_reg);

    always_comb begin
        s4_flags_next          = s3_flags_reg;
        s4_flags_next.in1      = (s3_d1_reg < s3_r2_reg);
        s4_flags_next.in2      = (s3_d2_reg < s3_r2_reg);
        s4_flags_next.use_end  = before_start || past_end;
        // nearest point is the start when the projection falls before it
        s4_flags_next.end_near = before_start ? (s3_d1_reg <= s3_r2_reg)
                                              : (s3_d2_reg <= s3_r2_reg);
    end

    csit_pkg::flags_t s4_flags_reg;
    logic [M-1:0]     s4_cr_reg, s4_rx_reg, s4_ry_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[4]) begin
            s4_flags_reg <= s4_flags_next;
            s4_cr_reg    <= s3_cr_reg[S-1] ? M'(-s3_cr_reg) : M'(s3_cr_reg);
            s4_rx_reg    <= s3_rdx_reg[P-1] ? M'(-s3_rdx_reg) : M'(s3_rdx_reg);
            s4_ry_reg    <= s3_rdy_reg[P-1] ? M'(-s3_rdy_reg) : M'(s3_rdy_reg);
        end
    end

    // ------------------------------------------------------------------------
    // Stage 5: partial products of the three squares
    // ------------------------------------------------------------------------
    csit_pkg::flags_t s5_flags_reg;
    logic [2*K-1:0]   s5_cr_hh_reg, s5_cr_hl_reg, s5_cr_ll_reg;
    logic [2*K-1:0]   s5_rx_hh_reg, s5_rx_hl_reg, s5_rx_ll_reg;
    logic [2*K-1:0]   s5_ry_hh_reg, s5_ry_hl_reg, s5_ry_ll_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[5]) begin
            s5_flags_reg <= s4_flags_reg;
            s5_cr_hh_reg <= (2*K)'(s4_cr_reg[M-1:K]) * (2*K)'(s4_cr_reg[M-1:K]);
            s5_cr_hl_reg <= (2*K)'(s4_cr_reg[M-1:K]) * (2*K)'(s4_cr_reg[K-1:0]);
            s5_cr_ll_reg <= (2*K)'(s4_cr_reg[K-1:0]) * (2*K)'(s4_cr_reg[K-1:0]);
            s5_rx_hh_reg <= (2*K)'(s4_rx_reg[M-1:K]) * (2*K)'(s4_rx_reg[M-1:K]);
            s5_rx_hl_reg <= (2*K)'(s4_rx_reg[M-1:K]) * (2*K)'(s4_rx_reg[K-1:0]);
            s5_rx_ll_reg <= (2*K)'(s4_rx_reg[K-1:0]) * (2*K)'(s4_rx_reg[K-1:0]);
            s5_ry_hh_reg <= (2*K)'(s4_ry_reg[M-1:K]) * (2*K)'(s4_ry_reg[M-1:K]);
            s5_ry_hl_reg <= (2*K)'(s4_ry_reg[M-1:K]) * (2*K)'(s4_ry_reg[K-1:0]);
            s5_ry_ll_reg <= (2*K)'(s4_ry_reg[K-1:0]) * (2*K)'(s4_ry_reg[K-1:0]);
        end
    end

    // ------------------------------------------------------------------------
    // Stage 6: merge the radius-side partials, r^2*|d|^2 = (r*dx)^2 + (r*dy)^2
    // ------------------------------------------------------------------------
    csit_pkg::flags_t s6_flags_reg;
    logic [2*K-1:0]   s6_cr_hh_reg, s6_cr_hl_reg, s6_cr_ll_reg;
    logic [2*K:0]     s6_rd_hh_reg, s6_rd_hl_reg, s6_rd_ll_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[6]) begin
            s6_flags_reg <= s5_flags_reg;
            s6_cr_hh_reg <= s5_cr_hh_reg;
            s6_cr_hl_reg <= s5_cr_hl_reg;
            s6_cr_ll_reg <= s5_cr_ll_reg;
            s6_rd_hh_reg <= (2*K+1)'(s5_rx_hh_reg) + (2*K+1)'(s5_ry_hh_reg);
            s6_rd_hl_reg <= (2*K+1)'(s5_rx_hl_reg) + (2*K+1)'(s5_ry_hl_reg);
            s6_rd_ll_reg <= (2*K+1)'(s5_rx_ll_reg) + (2*K+1)'(s5_ry_ll_reg);
        end
    end

    // ------------------------------------------------------------------------
    // Stage 7: assemble both squares, hi^2*2^2K + 2*hi*lo*2^K + lo^2
    // ------------------------------------------------------------------------
    csit_pkg::flags_t s7_flags_reg;
    logic [W-1:0]     s7_cr2_reg, s7_rd2_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[7]) begin
            s7_flags_reg <= s6_flags_reg;
            s7_cr2_reg   <= (W'(s6_cr_hh_reg) << (2*K)) + (W'(s6_cr_hl_reg) << (K+1)) +
                            W'(s6_cr_ll_reg);
            s7_rd2_reg   <= (W'(s6_rd_hh_reg) << (2*K)) + (W'(s6_rd_hl_reg) << (K+1)) +
                            W'(s6_rd_ll_reg);
        end
    end

    // ------------------------------------------------------------------------
    // Output: final compare and mode decision
    // ------------------------------------------------------------------------
    logic near, hit;

    always_comb begin
        // near: distance from the closed segment to the center within radius
        near = s7_flags_reg.use_end ? s7_flags_reg.end_near : (s7_cr2_reg <= s7_rd2_reg);
        if (s7_flags_reg.reject) begin
            hit = 1'b0;
        end else if (!s7_flags_reg.strict) begin
            hit = near;
        end else if (s7_flags_reg.in1 && s7_flags_reg.in2) begin
            hit = 1'b0;     // wholly inside never crosses the perimeter
        end else if (s7_flags_reg.in1 || s7_flags_reg.in2) begin
            hit = 1'b1;     // one end in, one out: must cross
        end else begin
            hit = near;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[NS+1]) begin
            m_tdata_reg <= 8'(hit);
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `CSIT_ASSERT_NOW(a_empty_out_accepts, !m_tvalid_reg, s_tready, "input stalled with empty output")
    `CSIT_ASSERT_NEXT(a_reject_misses, stage_valid_reg[NS] && stage_en[NS+1] && s7_flags_reg.reject, m_tvalid && !m_tdata[0], "rejected segment reported a hit")
    `CSIT_ASSERT_NEXT(a_strict_inside_misses, stage_valid_reg[NS] && stage_en[NS+1] && s7_flags_reg.strict && s7_flags_reg.in1 && s7_flags_reg.in2, !m_tdata[0], "strict mode hit with both ends inside")
    `CSIT_ASSERT_NEXT(a_strict_cross_hits, stage_valid_reg[NS] && stage_en[NS+1] && s7_flags_reg.strict && !s7_flags_reg.reject && (s7_flags_reg.in1 != s7_flags_reg.in2), m_tdata[0], "strict mode missed a crossing")

endmodule

// ===== bench/circle_segment_intersect_test_unit_tb.sv =====
// ----------------------------------------------------------------------------
// circle_segment_intersect_test_unit_tb
// Self-checking bench for the circle/segment intersection test unit.
// ----------------------------------------------------------------------------
// Segments go in on the slave stream and hit bits come back on the master
// stream. A behavioral hit predictor, kept in step with every APB write,
// supplies the expected bit for each accepted segment, and a FIFO of those
// bits is compared against each result transfer in order. A short table of
// hand-picked segments runs first: zero radius, degenerate segments, both
// ends inside, one end inside, tangents, ends on the perimeter, the
// bounding-square rejection and the coordinate extremes. Randomized phases
// follow, each with its own circle and an idling pattern on either
// stream side.
// ----------------------------------------------------------------------------
module circle_segment_intersect_test_unit_tb;
    import csit_pkg::*;

    localparam int COORD      = 24;
    localparam int DATA_W     = ((4*COORD+7)/8)*8;
    localparam int COORD_MIN  = -(1 << (COORD-1));
    localparam int COORD_MAX  = (1 << (COORD-1)) - 1;
    localparam int RADIUS_MAX = (1 << (COORD-1)) - 1;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 12;
    localparam int LATENCY        = 8;    // seven stages plus the output register
    localparam int DRAIN_CYCLES   = LATENCY + 4;
    localparam int HOLD_CYCLES    = 80;   // long receiver hold-off, fills the pipe
    localparam int TIMEOUT_CYCLES = 200000;

    localparam int DIR_ROWS        = 24;
    localparam int RAND_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int WANT_PRED       = -1;  // table row without a typed-in result

    // Index with no register behind it; writes there must change nothing
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic                    cmd;
        logic signed [COORD-1:0] sx;
        logic signed [COORD-1:0] sy;
        logic signed [COORD-1:0] ex;
        logic signed [COORD-1:0] ey;
    } seg_t;

    typedef struct {
        logic signed [COORD-1:0] cx;
        logic signed [COORD-1:0] cy;
        logic [COORD-2:0]        r;
    } circle_t;

    typedef struct {
        int   grp;
        logic cmd;
        int   sx;
        int   sy;
        int   ex;
        int   ey;
        int   want;
    } dir_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata;   // start_x, start_y, end_x, end_y from bit 0 up
    logic                  s_tuser;   // command
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;   // hit, then zero padding
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    circle_t  circle;          // mirror of the circle registers
    logic     expected_hits[$];
    logic     exp_hit;
    int       mismatches;
    int       src_idle_pct;
    int       sink_stall_pct;
    int       hold_reqs;
    int       hold_seen;
    int       hold_left;
    dir_row_t dir_rows[DIR_ROWS];

    circle_segment_intersect_test_unit #(
        .COORD_BITS(COORD)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial aclk = 1'b0;
    always #(CLK_PERIOD/2) aclk = ~aclk;

    // Hard stop in case a handshake never completes
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Hit predictor. Exact integer geometry: squared distances against the
    // squared radius, never a square root. Coordinates fit in 25-bit
    // differences, so dot and cross products fit in a longint; only the final
    // perpendicular test (cross^2 against r^2 * |d|^2) needs 128 bits.
    // ------------------------------------------------------------------------
    function automatic logic predict_hit(seg_t s, circle_t c);
        longint x1, y1, x2, y2, cx, cy, r, r2;
        longint dx, dy, wx, wy, dot, dd, d1, d2, cr;
        logic signed [127:0] cr_w, r2_w, dd_w;
        x1 = s.sx;
        y1 = s.sy;
        x2 = s.ex;
        y2 = s.ey;
        cx = c.cx;
        cy = c.cy;
        r  = c.r;
        // drop segments whose two ends sit past one side of the bounding square
        if ((x1 > cx + r && x2 > cx + r) || (x1 < cx - r && x2 < cx - r) ||
            (y1 > cy + r && y2 > cy + r) || (y1 < cy - r && y2 < cy - r))
            return 1'b0;
        r2 = r * r;
        d1 = (x1 - cx) * (x1 - cx) + (y1 - cy) * (y1 - cy);
        d2 = (x2 - cx) * (x2 - cx) + (y2 - cy) * (y2 - cy);
        if (s.cmd == CMD_STRICT) begin
            // a point on the perimeter is not inside
            if (d1 < r2 && d2 < r2)
                return 1'b0;
            if (d1 < r2 || d2 < r2)
                return 1'b1;
        end
        // least distance from the center to the closed segment
        dx  = x2 - x1;
        dy  = y2 - y1;
        wx  = cx - x1;
        wy  = cy - y1;
        dot = wx * dx + wy * dy;
        dd  = dx * dx + dy * dy;
        if (dot <= 0)
            return d1 <= r2;
        if (dot >= dd)
            return d2 <= r2;
        cr   = dx * wy - dy * wx;
        cr_w = cr;
        r2_w = r2;
        dd_w = dd;
        return (cr_w * cr_w) <= (r2_w * dd_w);
    endfunction

    // Coordinate within the radius plus two of a center coordinate, wrapping at
    // the edges of the coordinate range like the hardware does
    function automatic logic signed [COORD-1:0] near_coord(logic signed [COORD-1:0] ctr,
                                                           logic [COORD-2:0] r);
        longint span;
        longint off;
        span = 2 * longint'(r) + 4;
        off  = longint'($urandom_range(0, int'(span))) - span / 2;
        return COORD'(longint'(ctr) + off);
    endfunction

    function automatic logic signed [COORD-1:0] extreme_coord();
        case ($urandom_range(0, 3))
            0:       return COORD'(COORD_MIN);
            1:       return COORD'(COORD_MAX);
            2:       return '0;
            default: return COORD'($urandom);
        endcase
    endfunction

    // Mostly segments around the circle, where the interesting decisions
    // are; the rest is degenerate, wide open or pinned to the range limits
    function automatic seg_t random_segment(circle_t c);
        seg_t s;
        s.cmd = $urandom_range(0, 1) ? CMD_STRICT : CMD_INCLUSIVE;
        s.sx  = near_coord(c.cx, c.r);
        s.sy  = near_coord(c.cy, c.r);
        s.ex  = near_coord(c.cx, c.r);
        s.ey  = near_coord(c.cy, c.r);
        case ($urandom_range(0, 9))
            6: begin
                s.ex = s.sx;
                s.ey = s.sy;
            end
            7: begin
                s.sx = COORD'($urandom);
                s.sy = COORD'($urandom);
                s.ex = COORD'($urandom);
                s.ey = COORD'($urandom);
            end
            8: begin
                s.ex = COORD'($urandom);
                s.ey = COORD'($urandom);
            end
            9: begin
                s.sx = extreme_coord();
                s.sy = extreme_coord();
                s.ex = extreme_coord();
                s.ey = extreme_coord();
            end
            default: ;
        endcase
        return s;
    endfunction

    function automatic circle_t dir_circle(int grp);
        circle_t c;
        case (grp)
            1: begin
                c.cx = 100;
                c.cy = -50;
                c.r  = 30;
            end
            default: begin
                c.cx = COORD'(COORD_MIN);
                c.cy = COORD'(COORD_MAX);
                c.r  = RADIUS_MAX;
            end
        endcase
        return c;
    endfunction

    function automatic circle_t rand_circle(int phase);
        circle_t c;
        c.cx = COORD'($urandom);
        c.cy = COORD'($urandom);
        case (phase)
            0: c.r = 0;
            1: c.r = $urandom_range(1, 40);
            2: c.r = $urandom_range(0, RADIUS_MAX);
            3: begin
                c.cx = COORD'(COORD_MAX);
                c.cy = COORD'(COORD_MIN);
                c.r  = RADIUS_MAX;
            end
            4: c.r = $urandom_range(1, 400);
            5: begin
                c.cx = '0;
                c.cy = '0;
                c.r  = $urandom_range(1000, 100000);
            end
            6: begin
                c.cx = COORD'(COORD_MAX - 5);
                c.cy = COORD'(COORD_MAX - 5);
                c.r  = $urandom_range(1, 20);
            end
            default: c.r = $urandom_range(0, RADIUS_MAX >> 8);
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // APB write: setup cycle, then access cycle until pready. Mirror the
    // value into the predictor's copy of the circle.
    // ------------------------------------------------------------------------
    task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_CENTER_X: circle.cx = data[COORD-1:0];
            REG_CENTER_Y: circle.cy = data[COORD-1:0];
            REG_RADIUS:   circle.r  = data[COORD-2:0];
            default:      ;   // no register there
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Load all three circle registers, then write junk to the unused index;
    // with noisy_hi set, fill the bits above each register with junk, which the unit must ignore
    task automatic load_circle(circle_t c, bit noisy_hi);
        logic [CFG_DATA_W-1:0] cx_w, cy_w, r_w;
        cx_w = {{(CFG_DATA_W-COORD){c.cx[COORD-1]}}, c.cx};
        cy_w = {{(CFG_DATA_W-COORD){c.cy[COORD-1]}}, c.cy};
        r_w  = {{(CFG_DATA_W-COORD+1){1'b0}}, c.r};
        if (noisy_hi) begin
            cx_w[CFG_DATA_W-1:COORD]   = $urandom;
            cy_w[CFG_DATA_W-1:COORD]   = $urandom;
            r_w[CFG_DATA_W-1:COORD-1]  = $urandom;
        end
        apb_write(REG_CENTER_X, cx_w);
        apb_write(REG_CENTER_Y, cy_w);
        apb_write(REG_RADIUS, r_w);
        apb_write(REG_UNUSED, $urandom);
    endtask

    // Offer one segment, idling first as the current phase asks. Leave
    // s_tvalid high on return so back-to-back transfers need no re-raise.
    task automatic send_segment(seg_t s, int want);
        @(negedge aclk);
        while (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata  <= DATA_W'({s.ey, s.ex, s.sy, s.sx});
        s_tuser  <= s.cmd;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (want == WANT_PRED)
            expected_hits.push_back(predict_hit(s, circle));
        else
            expected_hits.push_back(want[0]);
    endtask

    // Drop s_tvalid, wait for every outstanding result, then let the
    // pipeline run empty before touching the registers
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_hits.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls per phase, plus a long hold-off on request.
    // The hold-off is counted here so the sender keeps offering meanwhile.
    // ------------------------------------------------------------------------
    initial begin
        m_tready  = 1'b0;
        hold_seen = 0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_seen != hold_reqs) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    // Result checker: compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_hits.size() == 0) begin
                $error("hit: expected no transfer, got %0d", m_tdata[0]);
                mismatches++;
            end else begin
                exp_hit = expected_hits.pop_front();
                if (m_tdata[0] !== exp_hit) begin
                    $error("hit: expected %0d, got %0d", exp_hit, m_tdata[0]);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        seg_t seg;
        int   grp;
        int   i;
        int   p;
        int   n;

        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = CMD_INCLUSIVE;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        mismatches     = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_reqs      = 0;
        circle.cx      = '0;
        circle.cy      = '0;
        circle.r       = '0;

        // Group 0 runs on the reset circle (center at origin, zero radius),
        // group 1 on a small circle, group 2 on the largest circle pinned to
        // a corner of the coordinate range.
        dir_rows = '{
            // zero radius: the circle is the origin
            '{0, CMD_INCLUSIVE, 0, 0, 0, 0, 1},                          // point on it
            '{0, CMD_STRICT,    0, 0, 0, 0, 1},                          // on perimeter
            '{0, CMD_INCLUSIVE, 1, 1, 1, 1, 0},                          // past the square
            '{0, CMD_INCLUSIVE, -5, 0, 5, 0, 1},                         // through origin
            '{0, CMD_INCLUSIVE, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0},
            '{0, CMD_STRICT,    COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 0},
            '{0, CMD_INCLUSIVE, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, WANT_PRED},
            '{0, CMD_STRICT,    COORD_MIN, 0, COORD_MAX, 0, WANT_PRED},
            // center (100,-50), radius 30
            '{1, CMD_STRICT,    95, -45, 105, -55, 0},                   // both inside
            '{1, CMD_INCLUSIVE, 95, -45, 105, -55, 1},                   // inside counts
            '{1, CMD_STRICT,    100, -50, 200, -50, 1},                  // one end inside
            '{1, CMD_STRICT,    50, -50, 150, -50, WANT_PRED},           // crosses twice
            '{1, CMD_INCLUSIVE, 70, -80, 130, -80, WANT_PRED},           // tangent
            '{1, CMD_STRICT,    70, -80, 130, -80, WANT_PRED},
            '{1, CMD_STRICT,    70, -50, 130, -50, WANT_PRED},           // ends on perimeter
            '{1, CMD_STRICT,    130, -50, 130, -50, WANT_PRED},          // point on perimeter
            '{1, CMD_INCLUSIVE, 131, -50, 200, 0, 0},                    // right of square
            '{1, CMD_INCLUSIVE, 125, -25, 135, -15, WANT_PRED},          // square corner
            '{1, CMD_INCLUSIVE, 160, -50, 200, -10, WANT_PRED},          // foot off segment
            // largest radius, center at the (min, max) corner
            '{2, CMD_INCLUSIVE, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, WANT_PRED},
            '{2, CMD_STRICT,    COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, WANT_PRED},
            '{2, CMD_STRICT,    COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, WANT_PRED},
            '{2, CMD_INCLUSIVE, 0, 0, COORD_MAX, COORD_MIN, WANT_PRED},
            '{2, CMD_STRICT,    COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, WANT_PRED}
        };

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table, no idling; reload the circle whenever the group moves
        grp = 0;
        for (i = 0; i < DIR_ROWS; i++) begin
            if (dir_rows[i].grp != grp) begin
                grp = dir_rows[i].grp;
                settle();
                load_circle(dir_circle(grp), 1'b0);
            end
            seg.cmd = dir_rows[i].cmd;
            seg.sx  = COORD'(dir_rows[i].sx);
            seg.sy  = COORD'(dir_rows[i].sy);
            seg.ex  = COORD'(dir_rows[i].ex);
            seg.ey  = COORD'(dir_rows[i].ey);
            send_segment(seg, dir_rows[i].want);
        end

        // Random phases: new circle each, idling pattern rotating through
        // none, sender-heavy, receiver-heavy and light on both sides
        for (p = 0; p < RAND_PHASES; p++) begin
            settle();
            load_circle(rand_circle(p), 1'b1);
            case (p % 4)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct   = 78;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 78;
                end
                default: begin
                    src_idle_pct   = 18;
                    sink_stall_pct = 18;
                end
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                // hold the receiver off while the sender keeps pushing, so the
                // pipeline fills and back-pressures s_tready
                if (p == 0 && n == 10)
                    hold_reqs++;
                send_segment(random_segment(circle), WANT_PRED);
            end
        end

        settle();
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== circle_segment_intersect_test_unit.f =====
+incdir+hw/rtl
hw/rtl/csit_pkg.sv
hw/rtl/circle_segment_intersect_test_unit.sv
bench/circle_segment_intersect_test_unit_tb.sv
